// ===== src/irm_pkg.sv =====
`timescale 1ns / 1ps

package irm_pkg;

    // default configuration of the monitor
    localparam int SAMPLES_DEF  = 12;
    localparam int ADC_BITS_DEF = 12;

    // result constants
    localparam logic [12:0] RES_CAP   = 13'd5000;
    localparam logic [15:0] RES_SAT   = 16'hFFFF;
    localparam int          SMALL_SUM = 100;

    // configuration register indexes
    localparam logic REG_BIAS = 1'b0;
    localparam logic REG_THR  = 1'b1;

    // event codes
    localparam logic [1:0] EV_LOW     = 2'd0;
    localparam logic [1:0] EV_SWITCH  = 2'd1;
    localparam logic [1:0] EV_BRIDGED = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIM,
        S_MUL1,
        S_MUL2,
        S_DIV_INIT,
        S_DIV,
        S_STORE,
        S_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic trim;
        logic mul1;
        logic mul2;
        logic div_init;
        logic div_step;
        logic store_q;
        logic emit;
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last_sample;
        logic bridged;
        logic div_done;
        logic pass;
        logic out_busy;
    } t_ctrl_stat;

endpackage

// ===== src/insulation_resistance_monitor.sv =====
`timescale 1ns / 1ps
// an item that does not end a group is taken and gives no result; a group-end item is
// trimmed and emitted in the baseline phase, and in the bridged phase goes through the
// multiplies and the shared bit-serial divider (NN = 51 bits at the defaults), run once
// per side, before it is emitted, plus any wait for the last result
// throughput: one item per cycle inside a group; no item is taken while a group end is at work
// reset: synchronous active-low i_rst_n clears phase, group sums, extremes and config registers
module insulation_resistance_monitor import irm_pkg::*; #(
    parameter int SAMPLES  = SAMPLES_DEF,
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: pos_sample, neg_sample
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [((2*ADC_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [16:0]                         i_cfg_data,
    // tdata: event_res, switch_pos_closed, switch_neg_closed, resistance,
    //        resistance_pos, resistance_neg, pos_trimmed_sum, neg_trimmed_sum
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [87:0]                         o_m_axis_tdata
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    logic [1:0]  event_res;
    logic        swp, swn;
    logic [12:0] res;
    logic [15:0] res_p, res_n, tsum_p, tsum_n;

    assign o_cfg_ready = 1'b1;

    // sequencing of group-end work
    irm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    // accumulation, arithmetic and result register
    irm_datapath #(
        .SAMPLES  (SAMPLES),
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_pos_sample        (i_s_axis_tdata[ADC_BITS-1:0]),
        .i_neg_sample        (i_s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_cfg_wr            (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_value         (i_cfg_data),
        .i_out_ready         (i_m_axis_tready),
        .o_out_valid         (o_m_axis_tvalid),
        .o_event_res         (event_res),
        .o_switch_pos_closed (swp),
        .o_switch_neg_closed (swn),
        .o_resistance        (res),
        .o_resistance_pos    (res_p),
        .o_resistance_neg    (res_n),
        .o_pos_trimmed_sum   (tsum_p),
        .o_neg_trimmed_sum   (tsum_n)
    );

    // result packing, lowest field first
    assign o_m_axis_tdata = {7'd0, tsum_n, tsum_p, res_n, res_p, res, swn, swp, event_res};

endmodule

// ===== src/irm_ctrl.sv =====
`timescale 1ns / 1ps

module irm_ctrl import irm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_ctrl_stat i_stat,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.last_sample) n_state = S_TRIM;
            end
            S_TRIM: begin
                n_state = i_stat.bridged ? S_MUL1 : S_EMIT;
            end
            S_MUL1:     n_state = S_MUL2;
            S_MUL2:     n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) n_state = S_STORE;
            end
            S_STORE: begin
                n_state = i_stat.pass ? S_EMIT : S_MUL2;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_TRIM:     o_cmd.trim     = 1'b1;
            S_MUL1:     o_cmd.mul1     = 1'b1;
            S_MUL2:     o_cmd.mul2     = 1'b1;
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_STORE:    o_cmd.store_q  = 1'b1;
            S_EMIT:     o_cmd.emit     = !i_stat.out_busy;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/irm_datapath.sv =====
`timescale 1ns / 1ps

module irm_datapath import irm_pkg::*; #(
    parameter int SAMPLES  = SAMPLES_DEF,
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_ctrl_stat          o_stat,
    input  logic [ADC_BITS-1:0] i_pos_sample,
    input  logic [ADC_BITS-1:0] i_neg_sample,
    input  logic                i_cfg_wr,
    input  logic                i_cfg_index,
    input  logic [16:0]         i_cfg_value,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_event_res,
    output logic                o_switch_pos_closed,
    output logic                o_switch_neg_closed,
    output logic [12:0]         o_resistance,
    output logic [15:0]         o_resistance_pos,
    output logic [15:0]         o_resistance_neg,
    output logic [15:0]         o_pos_trimmed_sum,
    output logic [15:0]         o_neg_trimmed_sum
);

    localparam int IDX_W  = $clog2(SAMPLES);
    localparam int SUM_W  = ADC_BITS + $clog2(SAMPLES);
    localparam int TOT_W  = SUM_W + 1;
    localparam int P1_W   = SUM_W + TOT_W;
    localparam int NUM_W  = P1_W + 16;
    localparam int DEN_W  = 2 * SUM_W;
    localparam int NN_W   = NUM_W + 2;
    localparam int DVS_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(NN_W);

    // configuration registers
    logic [15:0] r_bias;
    logic [16:0] r_thr;

    // group accumulation
    logic [IDX_W-1:0]    r_idx;
    logic [SUM_W-1:0]    r_sum_p, r_sum_n;
    logic [ADC_BITS-1:0] r_max_p, r_min_p, r_max_n, r_min_n;
    logic [SUM_W-1:0]    r_tp, r_tn;

    // phase state
    logic             r_bridged, r_hsp;
    logic [SUM_W-1:0] r_base_p, r_base_n;
    logic [15:0]      r_last_rp, r_last_rn;

    // arithmetic
    logic [P1_W-1:0]  r_prod1;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [NN_W-1:0]  r_dvd, r_quo;
    logic [DVS_W-1:0] r_dvs, r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pass;
    logic [15:0]      r_res_p, r_res_n;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_ev;
    logic        r_swp, r_swn;
    logic [12:0] r_res;
    logic [15:0] r_orp, r_orn, r_otp, r_otn;

    // operand selection
    logic [SUM_W-1:0] h_val, b_val, d_val, diff;
    logic [TOT_W-1:0] base_total, trim_total;
    assign h_val      = r_hsp ? r_base_p : r_base_n;
    assign b_val      = r_hsp ? r_tp : r_tn;
    assign d_val      = r_pass ? r_base_n : r_base_p;
    assign diff       = (h_val >= b_val) ? (h_val - b_val) : (b_val - h_val);
    assign base_total = TOT_W'(r_base_p) + TOT_W'(r_base_n);
    assign trim_total = TOT_W'(r_tp) + TOT_W'(r_tn);

    // divider step
    logic [DVS_W:0]   n_trial_in;
    logic             n_qbit;
    logic [DVS_W-1:0] n_rem;
    assign n_trial_in = {r_rem, r_dvd[NN_W-1]};
    assign n_qbit     = n_trial_in >= {1'b0, r_dvs};
    assign n_rem      = n_qbit ? DVS_W'(n_trial_in - {1'b0, r_dvs}) : DVS_W'(n_trial_in);

    // saturated quotient
    logic [15:0] n_q;
    assign n_q = (|r_quo[NN_W-1:16]) ? RES_SAT : r_quo[15:0];

    // side resistances of a bridged group
    logic        p_small, n_small;
    logic [15:0] n_rp, n_rn, n_side;
    assign p_small = r_base_p < SUM_W'(SMALL_SUM);
    assign n_small = r_base_n < SUM_W'(SMALL_SUM);
    always_comb begin
        if (r_hsp) begin
            if (p_small) begin
                n_rp = '0;
                n_rn = '0;
            end else begin
                n_rn = r_res_p;
                n_rp = n_small ? 16'(RES_CAP) : r_res_n;
            end
            n_side = n_rn;
        end else begin
            if (p_small) begin
                n_rp = r_res_n;
                n_rn = 16'(RES_CAP);
            end else if (n_small) begin
                n_rp = '0;
                n_rn = '0;
            end else begin
                n_rp = r_res_n;
                n_rn = r_res_p;
            end
            n_side = n_rp;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
            r_thr  <= '0;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                REG_BIAS: r_bias <= i_cfg_value[15:0];
                REG_THR:  r_thr  <= i_cfg_value;
                default:  r_thr  <= r_thr;
            endcase
        end
    end

    // sample accumulation and trimming
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_sum_p <= '0;
            r_sum_n <= '0;
            r_max_p <= '0;
            r_min_p <= '1;
            r_max_n <= '0;
            r_min_n <= '1;
        end else if (i_cmd.accept) begin
            r_idx   <= r_idx + 1'b1;
            r_sum_p <= r_sum_p + SUM_W'(i_pos_sample);
            r_sum_n <= r_sum_n + SUM_W'(i_neg_sample);
            if (i_pos_sample > r_max_p) r_max_p <= i_pos_sample;
            if (i_pos_sample < r_min_p) r_min_p <= i_pos_sample;
            if (i_neg_sample > r_max_n) r_max_n <= i_neg_sample;
            if (i_neg_sample < r_min_n) r_min_n <= i_neg_sample;
        end else if (i_cmd.trim) begin
            r_idx   <= '0;
            r_sum_p <= '0;
            r_sum_n <= '0;
            r_max_p <= '0;
            r_min_p <= '1;
            r_max_n <= '0;
            r_min_n <= '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trim) begin
            r_tp <= r_sum_p - SUM_W'(r_max_p) - SUM_W'(r_min_p);
            r_tn <= r_sum_n - SUM_W'(r_max_n) - SUM_W'(r_min_n);
        end
    end

    // multiplications and iterative division
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_prod1 <= P1_W'(diff) * P1_W'(base_total);
            r_pass  <= 1'b0;
        end
        if (i_cmd.mul2) begin
            r_num <= NUM_W'(r_prod1) * NUM_W'(r_bias);
            r_den <= DEN_W'(b_val) * DEN_W'(d_val);
        end
        if (i_cmd.div_init) begin
            r_dvd <= {1'b0, r_num, 1'b0} + NN_W'(r_den);
            r_dvs <= {r_den, 1'b0};
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= CNT_W'(NN_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[NN_W-2:0], 1'b0};
            r_quo <= {r_quo[NN_W-2:0], n_qbit};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.store_q) begin
            if (r_pass) r_res_n <= n_q;
            else        r_res_p <= n_q;
            r_pass <= 1'b1;
        end
    end

    // phase state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bridged   <= 1'b0;
            r_hsp       <= 1'b0;
            r_base_p    <= '0;
            r_base_n    <= '0;
            r_last_rp   <= '0;
            r_last_rn   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (!r_bridged) begin
                    r_base_p <= r_tp;
                    r_base_n <= r_tn;
                    r_otp    <= 16'(r_tp);
                    r_otn    <= 16'(r_tn);
                    r_orp    <= r_last_rp;
                    r_orn    <= r_last_rn;
                    if (32'(trim_total) <= 32'(r_thr)) begin
                        r_ev  <= EV_LOW;
                        r_res <= RES_CAP;
                        r_swp <= 1'b0;
                        r_swn <= 1'b0;
                    end else begin
                        r_bridged <= 1'b1;
                        r_hsp     <= r_tp >= r_tn;
                        r_ev      <= EV_SWITCH;
                        r_res     <= '0;
                        r_swp     <= r_tp >= r_tn;
                        r_swn     <= r_tp < r_tn;
                    end
                end else begin
                    r_bridged <= 1'b0;
                    r_last_rp <= n_rp;
                    r_last_rn <= n_rn;
                    r_orp     <= n_rp;
                    r_orn     <= n_rn;
                    r_otp     <= 16'(r_base_p);
                    r_otn     <= 16'(r_base_n);
                    r_ev      <= EV_BRIDGED;
                    r_swp     <= 1'b0;
                    r_swn     <= 1'b0;
                    r_res     <= (n_side > 16'(RES_CAP)) ? RES_CAP : n_side[12:0];
                end
            end
        end
    end

    // status to controller
    assign o_stat.last_sample = r_idx == IDX_W'(SAMPLES - 1);
    assign o_stat.bridged     = r_bridged;
    assign o_stat.div_done    = r_cnt == '0;
    assign o_stat.pass        = r_pass;
    assign o_stat.out_busy    = r_out_valid;

    assign o_out_valid         = r_out_valid;
    assign o_event_res         = r_ev;
    assign o_switch_pos_closed = r_swp;
    assign o_switch_neg_closed = r_swn;
    assign o_resistance        = r_res;
    assign o_resistance_pos    = r_orp;
    assign o_resistance_neg    = r_orn;
    assign o_pos_trimmed_sum   = r_otp;
    assign o_neg_trimmed_sum   = r_otn;

endmodule

// ===== dv/insulation_resistance_monitor_tb.sv =====
`timescale 1ns / 1ps

module insulation_resistance_monitor_tb;
    import irm_pkg::*;

    localparam int GROUP = SAMPLES_DEF;

    // one result item, fields in tdata order
    typedef struct {
        logic [1:0]  ev;
        logic        sw_pos;
        logic        sw_neg;
        logic [12:0] res;
        logic [15:0] res_pos;
        logic [15:0] res_neg;
        logic [15:0] trim_pos;
        logic [15:0] trim_neg;
    } t_reading;

    // bridge monitor predictor plus queue of pending readings
    class bridge_scoreboard;
        logic [15:0] bias;
        logic [16:0] thr;
        bit          bridged;
        bit          pos_high;
        int          cnt;
        int unsigned sum_p, sum_n, max_p, min_p, max_n, min_n;
        int unsigned base_p, base_n, last_rp, last_rn;
        t_reading    pending[$];
        int          errors;

        function new();
            bias = 0; thr = 0; bridged = 0; pos_high = 0;
            base_p = 0; base_n = 0; last_rp = 0; last_rn = 0; errors = 0;
            clear_group();
        endfunction

        function void clear_group();
            cnt = 0; sum_p = 0; sum_n = 0;
            max_p = 0; min_p = 4095; max_n = 0; min_n = 4095;
        endfunction

        function int unsigned side_res(int unsigned h, int unsigned b,
                                       int unsigned tot, int unsigned d);
            longint unsigned diff, num, den, q;
            diff = (h >= b) ? h - b : b - h;
            num  = diff * tot * bias;
            den  = longint'(b) * d;
            if (den == 0) return 65535;
            q = (2 * num + den) / (2 * den);
            return (q > 65535) ? 65535 : int'(q);
        endfunction

        function void note_sample(logic [11:0] ps, logic [11:0] ns);
            int unsigned tp, tn, tot, rp, rn, r;
            t_reading    e;
            sum_p += ps; sum_n += ns;
            if (ps > max_p) max_p = ps;
            if (ps < min_p) min_p = ps;
            if (ns > max_n) max_n = ns;
            if (ns < min_n) min_n = ns;
            cnt++;
            if (cnt < GROUP) return;
            tp = sum_p - max_p - min_p;
            tn = sum_n - max_n - min_n;
            clear_group();
            e.sw_pos = 0; e.sw_neg = 0;
            if (!bridged) begin
                base_p = tp; base_n = tn;
                if (tp + tn <= thr) begin
                    e.ev = EV_LOW; r = 5000;
                end else begin
                    pos_high = (tp >= tn);
                    bridged = 1;
                    e.ev = EV_SWITCH;
                    e.sw_pos = pos_high; e.sw_neg = !pos_high;
                    r = 0;
                end
            end else begin
                tot = base_p + base_n;
                bridged = 0;
                e.ev = EV_BRIDGED;
                if (pos_high) begin
                    if (base_p < SMALL_SUM) begin
                        rp = 0; rn = 0;
                    end else if (base_n < SMALL_SUM) begin
                        rn = side_res(base_p, tp, tot, base_p); rp = 5000;
                    end else begin
                        rn = side_res(base_p, tp, tot, base_p);
                        rp = side_res(base_p, tp, tot, base_n);
                    end
                    r = rn;
                end else begin
                    if (base_p < SMALL_SUM) begin
                        rp = side_res(base_n, tn, tot, base_n); rn = 5000;
                    end else if (base_n < SMALL_SUM) begin
                        rp = 0; rn = 0;
                    end else begin
                        rp = side_res(base_n, tn, tot, base_n);
                        rn = side_res(base_n, tn, tot, base_p);
                    end
                    r = rp;
                end
                last_rp = rp; last_rn = rn;
                if (r > 5000) r = 5000;
            end
            e.res = 13'(r); e.res_pos = 16'(last_rp); e.res_neg = 16'(last_rn);
            e.trim_pos = 16'(base_p); e.trim_neg = 16'(base_n);
            pending.push_back(e);
        endfunction

        function void check_reading(logic [87:0] d);
            t_reading e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result item: expected none, actual %h", $realtime, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d != {7'd0, e.trim_neg, e.trim_pos, e.res_neg, e.res_pos, e.res,
                      e.sw_neg, e.sw_pos, e.ev}) begin
                $display("%0t mismatch: expected ev=%0d swp=%0d swn=%0d r=%0d rp=%0d rn=%0d",
                         $realtime, e.ev, e.sw_pos, e.sw_neg, e.res, e.res_pos, e.res_neg);
                $display("%0t   expected tp=%0d tn=%0d", $realtime, e.trim_pos, e.trim_neg);
                $display("%0t   actual ev=%0d swp=%0d swn=%0d r=%0d rp=%0d rn=%0d tp=%0d tn=%0d",
                         $realtime, d[1:0], d[2], d[3], d[16:4], d[32:17], d[48:33],
                         d[64:49], d[80:65]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_index = REG_BIAS;
    logic [16:0] i_cfg_data = 0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [87:0] o_m_axis_tdata;

    bridge_scoreboard sb = new();
    int unsigned      cycles = 0;
    bit               stall_en = 1;
    int               burst = 0;

    insulation_resistance_monitor u_dut (.*);

    always #10 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_reading(o_m_axis_tdata);
    end

    // receiver stall pattern: quiet stretches, light stalls and heavy stalls
    always @(negedge i_clk) begin
        int ph;
        ph = (cycles / 300) % 3;
        if (!stall_en || ph == 0) i_m_axis_tready <= 1;
        else if (ph == 1) i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        else i_m_axis_tready <= ($urandom_range(0, 4) == 0);
    end

    task automatic write_reg(logic idx, logic [16:0] val);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_BIAS) sb.bias = val[15:0];
        else sb.thr = val;
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    // wait for all readings, then for the block to settle
    task automatic drain();
        if (burst != 0) begin
            burst = 0;
            i_s_axis_tvalid <= 0;
        end
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic send_sample(logic [11:0] ps, logic [11:0] ns);
        if (burst == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst = $urandom_range(1, 20);
        end
        burst--;
        i_s_axis_tvalid <= 1; i_s_axis_tdata <= {ns, ps};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_sample(ps, ns);
        @(negedge i_clk);
        if (burst == 0) i_s_axis_tvalid <= 0;
    endtask

    task automatic send_const_group(logic [11:0] ps, logic [11:0] ns);
        for (int k = 0; k < GROUP; k++) send_sample(ps, ns);
    endtask

    // one group of samples within spread of the given levels, clamped to the 12-bit range
    task automatic send_group(int lp, int ln, int spread);
        for (int k = 0; k < GROUP; k++) begin
            int a, b;
            a = lp + $urandom_range(0, 2 * spread) - spread;
            b = ln + $urandom_range(0, 2 * spread) - spread;
            if (a < 0) a = 0;
            if (a > 4095) a = 4095;
            if (b < 0) b = 0;
            if (b > 4095) b = 4095;
            send_sample(12'(a), 12'(b));
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: extremes, low total, small sums, zero divisor
        write_reg(REG_BIAS, 17'd65535);
        write_reg(REG_THR, 17'd0);
        send_const_group(0, 0);             // low pack total
        send_const_group(4095, 4095);       // switch request, positive high
        send_const_group(0, 0);             // bridged, zero divisor
        send_const_group(5, 4095);          // negative high, pos small
        send_const_group(2000, 0);          // bridged
        drain();
        write_reg(REG_THR, 17'd81900);
        send_const_group(4095, 4095);       // at threshold: low total
        drain();
        write_reg(REG_BIAS, 17'd0);
        write_reg(REG_THR, 17'd1);
        send_const_group(3000, 5);          // positive high, neg small
        send_const_group(1000, 1000);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            stall_en = (ph != 2);
            case (ph)
                0: begin write_reg(REG_BIAS, 17'd1000); write_reg(REG_THR, 17'd500); end
                1: begin write_reg(REG_BIAS, 17'd65535); write_reg(REG_THR, 17'd0); end
                2: begin write_reg(REG_BIAS, 17'd0); write_reg(REG_THR, 17'd81900); end
                default: begin
                    write_reg(REG_BIAS, 17'($urandom_range(0, 65535)));
                    write_reg(REG_THR, 17'($urandom_range(0, 20000)));
                end
            endcase
            for (int g = 0; g < 8; g++) begin
                if ($urandom_range(0, 9) == 0) begin
                    for (int k = 0; k < GROUP; k++)
                        send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
                end else begin
                    send_group($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 200));
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
